>>> design/ubfp_pkg.sv
// Package for the buffered UART ring pair: widths, operation and status codes,
// register indexes, word mask and word-length check. No dependencies.
`default_nettype none

package ubfp_pkg;

  localparam int WORD_W         = 9;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;
  localparam int CNT_OUT_W      = 6;
  localparam int DATA_BITS_W    = 4;
  localparam int PARITY_W       = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;
  localparam int RING_DEPTH_DEF = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_RX_WORD  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ     = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK     = 3'd3;
  localparam logic [OP_W-1:0] OP_TX_READY = 3'd4;
  localparam logic [OP_W-1:0] OP_TX_DONE  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RX_OFF = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_DUPLEX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_ECHO     = 2'd3;

  localparam logic [DATA_BITS_W-1:0] DATA_BITS_7   = 4'd7;
  localparam logic [DATA_BITS_W-1:0] DATA_BITS_8   = 4'd8;
  localparam logic [DATA_BITS_W-1:0] DATA_BITS_9   = 4'd9;
  localparam logic [PARITY_W-1:0]    PARITY_NONE   = 2'd0;

  // request into one ring
  typedef struct packed {
    logic              push;
    logic              rd;
    logic              pop;
    logic [WORD_W-1:0] word;
  } ubfp_ring_req_t;

  // ring occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } ubfp_ring_flags_t;

  function automatic logic [WORD_W-1:0] word_mask(input logic [DATA_BITS_W-1:0] db);
    logic [WORD_W-1:0] m;
    begin
      unique case (db)
        DATA_BITS_7: m = 9'h07F;
        DATA_BITS_8: m = 9'h0FF;
        DATA_BITS_9: m = 9'h1FF;
        default:     m = '0;
      endcase
      return m;
    end
  endfunction

  // data bits plus an optional parity bit must give 8 or 9
  function automatic logic config_valid(input logic [DATA_BITS_W-1:0] db,
                                        input logic [PARITY_W-1:0]    par);
    logic in_range;
    begin
      in_range = (db == DATA_BITS_7) || (db == DATA_BITS_8) || (db == DATA_BITS_9);
      if (par == PARITY_NONE) begin
        return in_range && (db != DATA_BITS_7);
      end else begin
        return in_range && (db != DATA_BITS_9);
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> design/ubfp_if.sv
// Channel interfaces for the buffered UART ring pair: command in, result out.
// Depends on ubfp_pkg.
`default_nettype none

interface ubfp_in_if import ubfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [WORD_W-1:0] word;

  modport source (output valid, output operation, output word, input ready);
  modport sink   (input valid, input operation, input word, output ready);
endinterface

interface ubfp_out_if import ubfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    out_word;
  logic                 out_valid;
  logic [STATUS_W-1:0]  status;
  logic [CNT_OUT_W-1:0] rx_count;
  logic [CNT_OUT_W-1:0] tx_free;
  logic                 line_tx_enabled;
  logic                 line_rx_enabled;
  logic                 config_ok;

  modport source (output valid, output out_word, output out_valid, output status,
                  output rx_count, output tx_free, output line_tx_enabled,
                  output line_rx_enabled, output config_ok, input ready);
  modport sink   (input valid, input out_word, input out_valid, input status,
                  input rx_count, input tx_free, input line_tx_enabled,
                  input line_rx_enabled, input config_ok, output ready);
endinterface

`default_nettype wire

>>> design/ubfp_ring.sv
// One ring buffer: word memory with registered read, head and tail pointers.
// Depends on ubfp_pkg.
`default_nettype none

module ubfp_ring import ubfp_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int PTR_W     = $clog2(RING_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ubfp_ring_req_t   req,
  output ubfp_ring_flags_t      flags,
  output logic [PTR_W-1:0]      count,
  output logic [WORD_W-1:0]     rdata_r
);

  logic [WORD_W-1:0] ring_mem [RING_DEPTH];
  logic [PTR_W-1:0]  head_r, tail_r, head_nxt, tail_nxt, head_inc, tail_inc;
  logic [PTR_W:0]    diff;

  assign head_inc = (head_r == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  assign flags.empty = (head_r == tail_r);
  assign flags.full  = (head_inc == tail_r);

  // occupancy modulo depth
  assign diff  = (head_r >= tail_r) ? ({1'b0, head_r} - {1'b0, tail_r})
               : ({1'b0, head_r} + (PTR_W+1)'(RING_DEPTH) - {1'b0, tail_r});
  assign count = diff[PTR_W-1:0];

  assign head_nxt = req.push ? head_inc : head_r;
  assign tail_nxt = req.pop  ? tail_inc : tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      ring_mem[head_r] <= req.word;
    end
    if (req.rd) begin
      rdata_r <= ring_mem[tail_r];
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> !flags.full) else $error("ring push while full");
  a_no_rd_empty: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd |-> !flags.empty) else $error("ring read while empty");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (req.pop && !req.push) |=> (count == $past(count) - 1'b1))
    else $error("ring count did not drop on pop");
`endif

endmodule

`default_nettype wire

>>> design/uart_buffered_fifo_pair.sv
// Buffered UART front end: receive ring, transmit ring, line direction control.
// A result follows its accepted command transaction through stage 1 (ring read stage)
// and then the output register, and stays there until the result transaction completes.
// Throughput: one transaction per cycle while the result side keeps up; a stalled
// result holds the command channel once stage 1 and the output register are full.
// Reset (synchronous, rst_n low): pointers zero, line tx and rx on, not armed, 8 data bits, no parity, full duplex.
`default_nettype none

module uart_buffered_fifo_pair import ubfp_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ubfp_in_if.sink                    in_ch,
  ubfp_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  // counts are widened to at least the result width before trimming
  localparam int CW    = (PTR_W > CNT_OUT_W) ? PTR_W : CNT_OUT_W;

  // configuration
  logic [DATA_BITS_W-1:0] data_bits_r;
  logic [PARITY_W-1:0]    parity_mode_r;
  logic                   half_duplex_r;
  logic                   no_echo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r   <= DATA_BITS_8;
      parity_mode_r <= PARITY_NONE;
      half_duplex_r <= 1'b0;
      no_echo_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_BITS:   data_bits_r   <= cfg_data;
        CFG_PARITY_MODE: parity_mode_r <= cfg_data[PARITY_W-1:0];
        CFG_HALF_DUPLEX: half_duplex_r <= cfg_data[0];
        CFG_NO_ECHO:     no_echo_r     <= cfg_data[0];
      endcase
    end
  end

  logic noecho;
  assign noecho = half_duplex_r && no_echo_r;

  // pipeline control: stage 1 holds the decoded transaction while ring reads land
  logic                s1_v_r, s1_ovalid_r, s1_from_tx_r;
  logic [STATUS_W-1:0] s1_status_r;
  logic                out_v_r;
  logic                s1_adv, accept;

  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // rings
  ubfp_ring_req_t   rx_req, tx_req;
  ubfp_ring_flags_t rx_flags, tx_flags;
  logic [PTR_W-1:0] rx_count, tx_count;
  logic [WORD_W-1:0] rx_rdata, tx_rdata;
  logic [WORD_W-1:0] masked_word;

  logic tx_on_r, rx_on_r, armed_r;
  logic tx_on_nxt, rx_on_nxt, armed_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic                ovalid_nxt, from_tx_nxt;

  assign masked_word = in_ch.word & word_mask(data_bits_r);

  // decode one command: ring requests, status and line direction
  always_comb begin
    rx_req      = '{push: 1'b0, rd: 1'b0, pop: 1'b0, word: masked_word};
    tx_req      = '{push: 1'b0, rd: 1'b0, pop: 1'b0, word: masked_word};
    status_nxt  = ST_OK;
    ovalid_nxt  = 1'b0;
    from_tx_nxt = 1'b0;
    tx_on_nxt   = tx_on_r;
    rx_on_nxt   = rx_on_r;
    armed_nxt   = armed_r;
    if (accept) begin
      unique case (in_ch.operation)
        OP_RX_WORD: begin
          if (!rx_on_r) begin
            status_nxt = ST_RX_OFF;
          end else if (rx_flags.full) begin
            status_nxt = ST_FULL;
          end else begin
            rx_req.push = 1'b1;
          end
        end
        OP_WRITE: begin
          if (tx_flags.full) begin
            status_nxt = ST_FULL;
          end else begin
            tx_req.push = 1'b1;
          end
        end
        OP_READ, OP_PEEK: begin
          if (rx_flags.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rx_req.rd  = 1'b1;
            rx_req.pop = (in_ch.operation == OP_READ);
            ovalid_nxt = 1'b1;
          end
        end
        OP_TX_READY: begin
          from_tx_nxt = 1'b1;
          if (tx_flags.empty) begin
            status_nxt = ST_EMPTY;
            // queue ran dry: next completion hands the line back to receive
            if (noecho) begin
              armed_nxt = 1'b1;
            end
          end else begin
            if (noecho) begin
              tx_on_nxt = 1'b1;
              rx_on_nxt = 1'b0;
            end
            tx_req.rd  = 1'b1;
            tx_req.pop = 1'b1;
            ovalid_nxt = 1'b1;
          end
        end
        OP_TX_DONE: begin
          if (armed_r && noecho) begin
            armed_nxt = 1'b0;
            tx_on_nxt = 1'b0;
            rx_on_nxt = 1'b1;
          end
        end
        default: begin
          // unused codes change nothing
        end
      endcase
    end
  end

  ubfp_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rx_req),
    .flags   (rx_flags),
    .count   (rx_count),
    .rdata_r (rx_rdata)
  );

  ubfp_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tx_req),
    .flags   (tx_flags),
    .count   (tx_count),
    .rdata_r (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_on_r <= 1'b1;
      rx_on_r <= 1'b1;
      armed_r <= 1'b0;
    end else begin
      tx_on_r <= tx_on_nxt;
      rx_on_r <= rx_on_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ovalid_r  <= ovalid_nxt;
      s1_status_r  <= status_nxt;
      s1_from_tx_r <= from_tx_nxt;
    end
  end

  // Stage 1 leaves only at an edge before any later transaction updates state,
  // so pointers and line state seen here are exactly those after its step.
  logic [CW-1:0]     rx_cnt_ext, tx_free_ext;
  logic [WORD_W-1:0] word_sel;

  assign rx_cnt_ext  = CW'(rx_count);
  assign tx_free_ext = CW'(RING_DEPTH - 1) - CW'(tx_count);
  assign word_sel    = !s1_ovalid_r ? '0 : (s1_from_tx_r ? tx_rdata : rx_rdata);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.out_word        <= word_sel;
      out_ch.out_valid       <= s1_ovalid_r;
      out_ch.status          <= s1_status_r;
      out_ch.rx_count        <= rx_cnt_ext[CNT_OUT_W-1:0];
      out_ch.tx_free         <= tx_free_ext[CNT_OUT_W-1:0];
      out_ch.line_tx_enabled <= tx_on_r;
      out_ch.line_rx_enabled <= rx_on_r;
      out_ch.config_ok       <= config_valid(data_bits_r, parity_mode_r);
    end
  end

  assign out_ch.valid = out_v_r;

`ifndef ASSERT_OFF
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("command taken while a result is stuck");
  a_line_never_dead: assert property (@(posedge clk) disable iff (!rst_n)
    tx_on_r || rx_on_r) else $error("line has neither direction enabled");
  a_empty_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (s1_status_r == ST_EMPTY)) |-> !s1_ovalid_r)
    else $error("empty status with a word");
  a_rx_off_only_noecho: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(rx_on_r) |-> $past(noecho))
    else $error("receiver turned off outside no-echo mode");
`endif

endmodule

`default_nettype wire
